// ===== rtl/desn_pkg.sv =====
// Shared types, constants and helpers for the directory entry name search block.
package desn_pkg;

  localparam int NameLen  = 11;
  localparam int BaseLen  = 8;
  localparam int PosW     = 4;
  localparam int CountW   = 8;

  localparam logic [7:0] AttrFileMask = 8'h18;
  localparam logic [7:0] AttrDirMask  = 8'hef;
  localparam logic [7:0] SpaceChar    = 8'h20;
  localparam logic [7:0] DotChar      = 8'h2e;
  localparam logic [7:0] NulChar      = 8'h00;

  localparam logic [CountW-1:0] MaxEntriesReset = 8'd224;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_END       = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_t;

  typedef enum logic {
    MODE_FILE = 1'b0,
    MODE_DIR  = 1'b1
  } mode_t;

  typedef enum logic {
    REQ_CHAR  = 1'b0,
    REQ_ENTRY = 1'b1
  } req_t;

  typedef enum logic {
    REG_SEARCH_MODE = 1'b0,
    REG_MAX_ENTRIES = 1'b1
  } reg_idx_t;

  typedef logic [7:0] name_t [NameLen];

  // query builder status seen by the top level
  typedef struct packed {
    logic begin_query;
    logic overflow;
  } query_stat_t;

  // merge stage verdict for one entry
  typedef struct packed {
    logic              fire;
    status_t           status;
    logic [CountW-1:0] index;
    logic              count_inc;
  } verdict_t;

endpackage

// ===== rtl/desn_query.sv =====
// Query name builder: collects characters into the 11-byte name buffer.
module desn_query (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_take,
  input  logic              entry_take,
  input  logic [7:0]        query_char,
  input  desn_pkg::mode_t   mode,
  output desn_pkg::name_t   name_buf,
  output desn_pkg::query_stat_t stat
);

  desn_pkg::name_t            name_buf_next;
  desn_pkg::name_t            base_buf;
  logic [desn_pkg::PosW-1:0]  pos;
  logic [desn_pkg::PosW-1:0]  pos_next;
  logic [desn_pkg::PosW-1:0]  base_pos;
  logic [desn_pkg::PosW-1:0]  limit;
  logic                       overflow;
  logic                       overflow_next;
  logic                       base_ovf;
  logic                       open;
  logic                       open_next;
  logic                       do_write;
  logic [7:0]                 up_char;

  always_comb begin
    // a character with no open query starts from a clean buffer
    for (int i = 0; i < desn_pkg::NameLen; i++) begin
      base_buf[i] = open ? name_buf[i] : desn_pkg::SpaceChar;
    end
    base_pos = open ? pos : '0;
    base_ovf = open & overflow;
    limit    = (mode == desn_pkg::MODE_DIR) ? desn_pkg::PosW'(desn_pkg::BaseLen)
                                            : desn_pkg::PosW'(desn_pkg::NameLen);
    up_char  = (query_char inside {[8'h61:8'h7a]}) ? (query_char - 8'h20) : query_char;

    name_buf_next = name_buf;
    pos_next      = pos;
    overflow_next = overflow;
    open_next     = open;
    do_write      = 1'b0;

    if (char_take) begin
      name_buf_next = base_buf;
      pos_next      = base_pos;
      overflow_next = base_ovf;
      open_next     = 1'b1;
      if (query_char != desn_pkg::NulChar && !base_ovf) begin
        if (base_pos >= limit) begin
          overflow_next = 1'b1;
        end else if (mode == desn_pkg::MODE_FILE && query_char == desn_pkg::DotChar &&
                     base_pos <= desn_pkg::PosW'(desn_pkg::BaseLen)) begin
          pos_next = desn_pkg::PosW'(desn_pkg::BaseLen);
        end else begin
          do_write = 1'b1;
          pos_next = base_pos + 1'b1;
        end
      end
      for (int i = 0; i < desn_pkg::NameLen; i++) begin
        if (do_write && base_pos == desn_pkg::PosW'(i)) begin
          name_buf_next[i] = up_char;
        end
      end
    end else if (entry_take) begin
      open_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < desn_pkg::NameLen; i++) begin
        name_buf[i] <= desn_pkg::SpaceChar;
      end
      pos      <= '0;
      overflow <= 1'b0;
      open     <= 1'b0;
    end else begin
      name_buf <= name_buf_next;
      pos      <= pos_next;
      overflow <= overflow_next;
      open     <= open_next;
    end
  end

  assign stat.begin_query = char_take & ~open;
  assign stat.overflow    = overflow;

endmodule

// ===== rtl/desn_lane.sv =====
// One byte comparator lane: query byte against entry name byte.
module desn_lane (
  input  logic [7:0] query_byte,
  input  logic [7:0] entry_byte,
  input  logic       lane_en,
  output logic       lane_eq
);

  // a lane outside the compared length always agrees
  assign lane_eq = ~lane_en | (query_byte == entry_byte);

endmodule

// ===== rtl/desn_merge.sv =====
// Merge stage: combines lane results with attribute check and entry counting.
module desn_merge (
  input  logic [desn_pkg::NameLen-1:0] lane_eq,
  input  desn_pkg::mode_t              mode,
  input  logic [7:0]                   attributes,
  input  logic                         first_zero,
  input  logic                         overflow,
  input  logic [desn_pkg::CountW-1:0]  entry_counter,
  input  logic [desn_pkg::CountW-1:0]  max_entries,
  output desn_pkg::verdict_t           verdict
);

  logic                        attr_ok;
  logic                        hit;
  logic [desn_pkg::CountW-1:0] count_plus;

  assign attr_ok = (mode == desn_pkg::MODE_DIR) ?
                   ((attributes & desn_pkg::AttrDirMask) == 8'h00) :
                   ((attributes & desn_pkg::AttrFileMask) == 8'h00);
  assign hit        = (&lane_eq) & attr_ok;
  // counter stays below max here, so the sum never wraps
  assign count_plus = entry_counter + 1'b1;

  always_comb begin
    verdict.fire      = 1'b1;
    verdict.status    = desn_pkg::ST_FOUND;
    verdict.index     = '0;
    verdict.count_inc = 1'b0;
    if (overflow) begin
      verdict.status = desn_pkg::ST_TOO_LONG;
    end else if (entry_counter >= max_entries) begin
      verdict.status = desn_pkg::ST_EXHAUSTED;
    end else if (first_zero) begin
      verdict.status = desn_pkg::ST_END;
    end else if (hit) begin
      verdict.status = desn_pkg::ST_FOUND;
      verdict.index  = entry_counter;
    end else begin
      verdict.count_inc = 1'b1;
      verdict.status    = desn_pkg::ST_EXHAUSTED;
      verdict.fire      = (count_plus == max_entries);
    end
  end

endmodule

// ===== rtl/dir_entry_name_search_top.sv =====
// Top level of the directory entry name search block.
// A result is valid in the cycle after the entry transfer that ends the search.
// Throughput: one item per cycle while in_stall is low; all 11 name bytes are compared in parallel lanes.
// in_stall is high only while a result sits in the output register and out_stall holds it.
// Reset (rst, synchronous): search_mode 0, max_entries 224, buffer all spaces,
// counters and flags cleared, no result pending.
module dir_entry_name_search_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  query_char,
  input  logic [63:0] entry_base_name,
  input  logic [23:0] entry_extension,
  input  logic [7:0]  entry_attributes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  search_status,
  output logic [7:0]  match_index,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  desn_pkg::mode_t              mode;
  logic [desn_pkg::CountW-1:0]  max_entries;
  logic [desn_pkg::CountW-1:0]  entry_counter;
  logic                         search_finished;
  logic                         in_xfer;
  logic                         char_take;
  logic                         entry_take;
  logic                         cfg_wr;
  desn_pkg::reg_idx_t           reg_sel;
  desn_pkg::name_t              name_buf;
  desn_pkg::name_t              entry_name;
  desn_pkg::query_stat_t        qstat;
  desn_pkg::verdict_t           verdict;
  logic [desn_pkg::NameLen-1:0] lane_eq;

  assign in_stall   = out_valid & out_stall;
  assign in_xfer    = in_valid & ~in_stall;
  assign char_take  = in_xfer & (req_type == desn_pkg::REQ_CHAR);
  assign entry_take = in_xfer & (req_type == desn_pkg::REQ_ENTRY) & ~search_finished;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = desn_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    case (reg_sel)
      desn_pkg::REG_SEARCH_MODE: prdata = {31'b0, mode};
      desn_pkg::REG_MAX_ENTRIES: prdata = {24'b0, max_entries};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= desn_pkg::MODE_FILE;
      max_entries <= desn_pkg::MaxEntriesReset;
    end else if (cfg_wr) begin
      case (reg_sel)
        desn_pkg::REG_SEARCH_MODE: mode <= desn_pkg::mode_t'(pwdata[0]);
        desn_pkg::REG_MAX_ENTRIES: max_entries <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  desn_query u_query (
    .clk        (clk),
    .rst        (rst),
    .char_take  (char_take),
    .entry_take (entry_take),
    .query_char (query_char),
    .mode       (mode),
    .name_buf   (name_buf),
    .stat       (qstat)
  );

  always_comb begin
    for (int i = 0; i < desn_pkg::BaseLen; i++) begin
      entry_name[i] = entry_base_name[63-8*i -: 8];
    end
    for (int i = 0; i < desn_pkg::NameLen - desn_pkg::BaseLen; i++) begin
      entry_name[desn_pkg::BaseLen+i] = entry_extension[23-8*i -: 8];
    end
  end

  for (genvar g = 0; g < desn_pkg::NameLen; g++) begin : g_lane
    desn_lane u_lane (
      .query_byte (name_buf[g]),
      .entry_byte (entry_name[g]),
      .lane_en    ((g < desn_pkg::BaseLen) || (mode == desn_pkg::MODE_FILE)),
      .lane_eq    (lane_eq[g])
    );
  end

  desn_merge u_merge (
    .lane_eq       (lane_eq),
    .mode          (mode),
    .attributes    (entry_attributes),
    .first_zero    (entry_name[0] == desn_pkg::NulChar),
    .overflow      (qstat.overflow),
    .entry_counter (entry_counter),
    .max_entries   (max_entries),
    .verdict       (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_counter   <= '0;
      search_finished <= 1'b0;
    end else if (qstat.begin_query) begin
      entry_counter   <= '0;
      search_finished <= 1'b0;
    end else if (entry_take) begin
      if (verdict.count_inc) begin
        entry_counter <= entry_counter + 1'b1;
      end
      if (verdict.fire) begin
        search_finished <= 1'b1;
      end
    end
  end

  // output register; a held result stalls the input side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (entry_take && verdict.fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (entry_take && verdict.fire) begin
      search_status <= verdict.status;
      match_index   <= verdict.index;
    end
  end

  a_result_from_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && req_type == desn_pkg::REQ_ENTRY))
    else $error("result appeared without an entry transfer");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && search_status != desn_pkg::ST_FOUND) |-> (match_index == 8'd0))
    else $error("match index nonzero on a non-found result");

  a_finished_after_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> search_finished)
    else $error("search not marked finished after its result");

  a_counter_bound: assert property (@(posedge clk) disable iff (rst)
    (entry_take && verdict.count_inc) |=> (entry_counter == $past(entry_counter) + 8'd1))
    else $error("entry counter did not advance on a missed entry");

endmodule

// ===== verif/tb_dir_entry_name_search_top.sv =====
// Self-checking testbench for dir_entry_name_search_top: directed and random name lookups.
module tb_dir_entry_name_search_top;
  import desn_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int MaxShown   = 10;
  localparam int PhaseItems = 150;
  localparam logic [63:0] OtherName = "NOMATCH!";

  typedef struct packed {
    status_t          status;
    logic [7:0]       index;
  } search_result_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = 1'b0;
  logic [7:0]  query_char = '0;
  logic [63:0] entry_base_name = '0;
  logic [23:0] entry_extension = '0;
  logic [7:0]  entry_attributes = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  search_status;
  logic [7:0]  match_index;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dir_entry_name_search_top i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirrored lookup state
  logic [7:0]      qname [NameLen];
  logic [PosW-1:0] qpos;
  bit              q_overflow;
  bit              q_open;
  bit              s_done;
  logic [7:0]      scanned;
  mode_t           cur_mode = MODE_FILE;
  logic [7:0]      entry_limit = MaxEntriesReset;

  search_result_t  pending [$];
  int              mismatches = 0;
  int              items_used = 0;
  int              cycle_count = 0;

  bit              gaps_on = 1'b0;
  int              burst_left = 0;
  stall_style_t    stall_style = STALL_NONE;
  int              stall_tick = 0;
  int              hold_req = 0;
  int              hold_left = 0;

  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= MaxShown) begin
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  function automatic void init_query(bit open_now);
    foreach (qname[i]) qname[i] = SpaceChar;
    qpos = '0;
    q_overflow = 1'b0;
    q_open = open_now;
    scanned = '0;
    s_done = 1'b0;
  endfunction

  function automatic void add_query_char(input logic [7:0] c);
    int cap;
    cap = (cur_mode == MODE_DIR) ? BaseLen : NameLen;
    if (!q_open) init_query(1'b1);
    if (c == NulChar || q_overflow) return;
    if (qpos >= cap) begin
      q_overflow = 1'b1;
      return;
    end
    // in file mode a dot up to position 8 skips to the extension
    if (cur_mode == MODE_FILE && c == DotChar && qpos <= BaseLen) begin
      qpos = PosW'(BaseLen);
      return;
    end
    if (c >= 8'h61 && c <= 8'h7a) c = c - 8'h20;
    qname[qpos] = c;
    qpos = qpos + 1'b1;
  endfunction

  // returns 1 when the entry ends the search
  function automatic bit scan_entry(input logic [63:0] base, input logic [23:0] ext,
                                    input logic [7:0] attr, output search_result_t res);
    int i, n;
    bit hit;
    logic [7:0] b;
    res.status = ST_FOUND;
    res.index = '0;
    if (s_done) return 1'b0;
    q_open = 1'b0;
    if (cur_mode == MODE_DIR) begin
      n = BaseLen;
      hit = (attr & AttrDirMask) == 0;
    end else begin
      n = NameLen;
      hit = (attr & AttrFileMask) == 0;
    end
    for (i = 0; i < n; i++) begin
      b = (i < BaseLen) ? base[63-8*i -: 8] : ext[23-8*(i-BaseLen) -: 8];
      if (b != qname[i]) hit = 1'b0;
    end
    if (q_overflow) res.status = ST_TOO_LONG;
    else if (scanned >= entry_limit) res.status = ST_EXHAUSTED;
    else if (base[63:56] == NulChar) res.status = ST_END;
    else if (hit) res.index = scanned;
    else begin
      scanned++;
      if (scanned < entry_limit) return 1'b0;
      res.status = ST_EXHAUSTED;
    end
    s_done = 1'b1;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : track
    search_result_t res;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("dir_entry_name_search_top regression: fail");
      $finish;
    end else if (rst) begin
      init_query(1'b0);
      cur_mode = MODE_FILE;
      entry_limit = MaxEntriesReset;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending.size() == 0) begin
          note_mismatch("result with nothing pending, status", 0, search_status);
        end else begin
          res = pending.pop_front();
          if (search_status !== res.status) begin
            note_mismatch("search_status", res.status, search_status);
          end
          if (match_index !== res.index) note_mismatch("match_index", res.index, match_index);
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (reg_idx_t'(paddr[2]) == REG_SEARCH_MODE) cur_mode = mode_t'(pwdata[0]);
        else entry_limit = pwdata[7:0];
      end
      if (in_valid && !in_stall) begin
        if (req_type == REQ_CHAR) begin
          items_used++;
          add_query_char(query_char);
        end else begin
          if (!s_done) items_used++;
          if (scan_entry(entry_base_name, entry_extension, entry_attributes, res)) begin
            pending.push_back(res);
          end
        end
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (rst) out_stall <= 1'b0;
    else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      case (stall_style)
        STALL_NONE: out_stall <= 1'b0;
        STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
        default: begin
          out_stall <= (stall_tick % 7) < 3;
          stall_tick++;
        end
      endcase
    end
  end

  function automatic logic [7:0] ok_attr();
    if (cur_mode == MODE_DIR) return $urandom_range(0, 1) ? ~AttrDirMask : 8'h00;
    return 8'($urandom) & ~AttrFileMask;
  endfunction

  function automatic logic [7:0] bad_attr();
    logic [7:0] a, m;
    m = (cur_mode == MODE_DIR) ? AttrDirMask : AttrFileMask;
    a = 8'($urandom);
    if ((a & m) == 0) a = a | (m & 8'h09);
    return a;
  endfunction

  function automatic logic [7:0] name_char();
    case ($urandom_range(0, 15))
      0: return 8'($urandom);
      1, 2: return DotChar;
      3, 4, 5, 6: return 8'($urandom_range(8'h61, 8'h7a));
      7, 8, 9, 10, 11: return 8'($urandom_range(8'h41, 8'h5a));
      default: return 8'($urandom_range(8'h30, 8'h39));
    endcase
  endfunction

  function automatic logic [63:0] rand_name();
    return {8'($urandom_range(1, 255)), 24'($urandom), 32'($urandom)};
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // with from_query set, base and ext are flip masks over the current query name
  task automatic send_item(req_t rt, logic [7:0] ch, logic [63:0] base, logic [23:0] ext,
                           logic [7:0] attr, bit from_query);
    int i;
    if (gaps_on) begin
      if (burst_left == 0) begin
        idle_cycles($urandom_range(1, 6));
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    @(negedge clk);
    if (from_query) begin
      for (i = 0; i < BaseLen; i++) base[63-8*i -: 8] = base[63-8*i -: 8] ^ qname[i];
      for (i = 0; i < 3; i++) ext[23-8*i -: 8] = ext[23-8*i -: 8] ^ qname[BaseLen+i];
    end
    in_valid <= 1'b1;
    req_type <= rt;
    query_char <= ch;
    entry_base_name <= base;
    entry_extension <= ext;
    entry_attributes <= attr;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_char(logic [7:0] c);
    send_item(REQ_CHAR, c, {$urandom, $urandom}, 24'($urandom), 8'($urandom), 1'b0);
  endtask

  task automatic send_entry(logic [63:0] b, logic [23:0] e, logic [7:0] a);
    send_item(REQ_ENTRY, 8'($urandom), b, e, a, 1'b0);
  endtask

  task automatic send_query_entry(logic [63:0] bmask, logic [23:0] emask, logic [7:0] a);
    send_item(REQ_ENTRY, 8'($urandom), bmask, emask, a, 1'b1);
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_drain();
    do idle_cycles(1); while (pending.size() != 0);
    idle_cycles(3);
  endtask

  task automatic apb_access(reg_idx_t r, bit wr, logic [31:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {r, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!wr && prdata !== data) note_mismatch("register read", data, prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_register(reg_idx_t r, logic [31:0] v);
    wait_drain();
    apb_access(r, 1'b1, v);
    apb_access(r, 1'b0, v);
  endtask

  task automatic test_reset_defaults();
    apb_access(REG_SEARCH_MODE, 1'b0, 32'(MODE_FILE));
    apb_access(REG_MAX_ENTRIES, 1'b0, 32'(MaxEntriesReset));
    // no query yet: entries are matched against an all-space name
    send_entry({8'h41, {7{SpaceChar}}}, {3{SpaceChar}}, 8'h00);
    send_query_entry('0, '0, 8'h00);
    send_entry(rand_name(), 24'($urandom), 8'($urandom));
  endtask

  task automatic test_file_names();
    send_text("a.Z");
    send_query_entry('0, '0, 8'h18);
    send_query_entry('0, '0, 8'he7);
    send_char(NulChar);
    send_char(8'h60);
    send_char(8'h7b);
    send_char(8'hff);
    send_char(8'h7a);
    send_entry({NulChar, 24'($urandom), 32'($urandom)}, 24'($urandom), 8'($urandom));
  endtask

  task automatic test_dir_names();
    set_register(REG_SEARCH_MODE, 32'(MODE_DIR));
    send_text("x.");
    send_query_entry('0, 24'($urandom), bad_attr());
    send_query_entry('0, 24'($urandom), ~AttrDirMask);
    // query begun in directory mode, finished in file mode
    send_text("ab");
    set_register(REG_SEARCH_MODE, 32'(MODE_FILE));
    send_text(".c");
    send_query_entry('0, '0, 8'h00);
  endtask

  task automatic test_entry_limits();
    set_register(REG_MAX_ENTRIES, 1);
    send_char("q");
    send_entry(OtherName, "TXT", 8'h00);
    set_register(REG_MAX_ENTRIES, 3);
    send_char("q");
    send_entry(OtherName, "TXT", 8'h00);
    send_entry(OtherName, "TXT", 8'h00);
    // limit dropped to the count mid-search: next entry is not examined
    set_register(REG_MAX_ENTRIES, 2);
    send_query_entry('0, '0, ok_attr());
    send_char("k");
    send_entry(OtherName, "TXT", 8'h00);
    send_char("m");
    send_entry({NulChar, 24'($urandom), 32'($urandom)}, 24'($urandom), 8'($urandom));
  endtask

  task automatic run_search();
    int n_chars, n_miss, i, pick, pos;
    logic [63:0] bm;
    logic [23:0] em;
    pick = $urandom_range(0, 19);
    n_chars = (pick < 2) ? 0 : (pick < 16) ? $urandom_range(1, 8) : $urandom_range(9, 13);
    for (i = 0; i < n_chars; i++) send_char(name_char());
    n_miss = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
    for (i = 0; i < n_miss; i++) begin
      em = (cur_mode == MODE_DIR) ? 24'($urandom) : '0;
      case ($urandom_range(0, 2))
        0: begin
          bm = '0;
          pos = $urandom_range(0, (cur_mode == MODE_DIR) ? BaseLen - 1 : NameLen - 1);
          if (pos < BaseLen) bm[63-8*pos -: 8] = 8'($urandom_range(1, 255));
          else em[23-8*(pos-BaseLen) -: 8] = 8'($urandom_range(1, 255));
          send_query_entry(bm, em, ok_attr());
        end
        1: send_query_entry('0, em, bad_attr());
        default: send_entry(rand_name(), 24'($urandom), 8'($urandom));
      endcase
    end
    pick = $urandom_range(0, 9);
    em = (cur_mode == MODE_DIR) ? 24'($urandom) : '0;
    if (pick < 6) send_query_entry('0, em, ok_attr());
    else if (pick < 8) begin
      send_entry({NulChar, 24'($urandom), 32'($urandom)}, 24'($urandom), 8'($urandom));
    end
    // trailing entry, which may arrive after the search is over
    if ($urandom_range(0, 3) == 0) send_entry(rand_name(), 24'($urandom), 8'($urandom));
  endtask

  task automatic test_backpressure();
    set_register(REG_MAX_ENTRIES, 32'(MaxEntriesReset));
    gaps_on = 1'b0;
    stall_style = STALL_NONE;
    @(posedge clk);
    hold_req = 400;
    repeat (12) begin
      send_char(name_char());
      send_query_entry('0, '0, ok_attr());
    end
    // sender rests until every result is in
    wait_drain();
    gaps_on = 1'b1;
    stall_style = STALL_RANDOM;
    repeat (8) run_search();
  endtask

  task automatic test_random_searches();
    int p, lim, stop_at;
    for (p = 0; p < 8; p++) begin
      set_register(REG_SEARCH_MODE, p % 2);
      case (p)
        0, 5: lim = 1;
        1, 6: lim = 255;
        default: lim = $urandom_range(2, 16);
      endcase
      set_register(REG_MAX_ENTRIES, lim);
      gaps_on = (p % 3) != 2;
      stall_style = stall_style_t'(p % 3);
      stop_at = items_used + PhaseItems;
      if (p == 1) begin
        // close any open query, then run the largest table to exhaustion
        send_entry({NulChar, 24'($urandom), 32'($urandom)}, 24'($urandom), 8'($urandom));
        send_text("LONGDIR");
        repeat (255) send_entry(rand_name(), 24'($urandom), ok_attr());
      end
      while (items_used < stop_at) run_search();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_file_names();
    test_dir_names();
    test_entry_limits();
    test_backpressure();
    test_random_searches();
    wait_drain();
    idle_cycles(8);
    if (mismatches == 0) begin
      $display("dir_entry_name_search_top regression: pass");
    end else begin
      $display("dir_entry_name_search_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/desn_pkg.sv
rtl/desn_query.sv
rtl/desn_lane.sv
rtl/desn_merge.sv
rtl/dir_entry_name_search_top.sv
verif/tb_dir_entry_name_search_top.sv
